// ----- src/date_validate_and_day_difference_defines.svh -----
// assertion macros shared by the date check rtl
`ifndef DATE_VALIDATE_AND_DAY_DIFFERENCE_DEFINES_SVH
`define DATE_VALIDATE_AND_DAY_DIFFERENCE_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define DVD_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("date check assertion failed");

// property whose consequent must hold in the cycle after its antecedent
`define DVD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("date check assertion failed");

`endif

// ----- src/dvd_pkg.sv -----
// types, constants and calendar tables for the date check block
`timescale 1ns / 1ps

package dvd_pkg;

    localparam int DAY_NUM_W = 22;
    localparam int YEAR_W    = 14;

    localparam logic [7:0] CHAR_DASH = 8'h2D;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [8:0] DAYS_PER_YEAR = 9'd365;

    // decoded date handed from the decode stage to the day count stage
    typedef struct packed {
        logic              ok;
        logic [YEAR_W-1:0] year;
        logic [3:0]        month;
        logic [4:0]        day;
        logic              leap;
        logic [6:0]        ceil100;
        logic [4:0]        ceil400;
    } dvd_date_t;

    // two ascii digits to a value
    function automatic logic [6:0] two_digit(input logic [3:0] tens, input logic [3:0] units);
        return 7'(7'(tens) * 7'd10) + 7'(units);
    endfunction

    // length of a month, month in 1..12
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // days in the months before this one, common year
    function automatic logic [8:0] days_before(input logic [3:0] month);
        logic [8:0] days;
        unique case (month)
            4'd1:    days = 9'd0;
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

// ----- src/dvd_in_if.sv -----
// channel carrying one pair of date strings
`timescale 1ns / 1ps

interface dvd_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] first_text_high;
    logic [15:0] first_text_low;
    logic [63:0] second_text_high;
    logic [15:0] second_text_low;

    modport source (
        output valid, first_text_high, first_text_low, second_text_high, second_text_low,
        input  ready
    );

    modport sink (
        input  valid, first_text_high, first_text_low, second_text_high, second_text_low,
        output ready
    );
endinterface

// ----- src/dvd_out_if.sv -----
// channel carrying validity, day numbers and their distance
`timescale 1ns / 1ps

interface dvd_out_if;
    logic        valid;
    logic        ready;
    logic        first_valid;
    logic        second_valid;
    logic [21:0] first_day_number;
    logic [21:0] second_day_number;
    logic [21:0] days_apart;

    modport source (
        output valid, first_valid, second_valid, first_day_number, second_day_number,
               days_apart,
        input  ready
    );

    modport sink (
        input  valid, first_valid, second_valid, first_day_number, second_day_number,
               days_apart,
        output ready
    );
endinterface

// ----- src/dvd_decode.sv -----
// decode stage: checks one dd-mm-yyyy string and registers its fields
`timescale 1ns / 1ps

module dvd_decode (
    input  logic               clk,
    input  logic               en,
    input  logic [63:0]        text_high,
    input  logic [15:0]        text_low,
    output dvd_pkg::dvd_date_t date
);
    import dvd_pkg::*;

    logic [7:0]  chr [10];
    logic [3:0]  dig [10];
    logic [9:0]  is_digit;
    logic        format_ok;
    logic [6:0]  day_raw;
    logic [6:0]  month_raw;
    logic [6:0]  century;
    logic [6:0]  yy;
    logic        month_ok;
    logic        leap;
    logic [4:0]  dim;
    logic        day_ok;
    dvd_date_t   date_next;
    dvd_date_t   date_reg;

    // split into characters, first character in the top byte
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            chr[i] = text_high[63 - 8*i -: 8];
        end
        chr[8] = text_low[15:8];
        chr[9] = text_low[7:0];
        for (int i = 0; i < 10; i++)
        begin
            is_digit[i] = (chr[i] >= CHAR_ZERO) && (chr[i] <= CHAR_NINE);
            dig[i]      = chr[i][3:0];
        end
    end

    // dashes at places two and five, digits elsewhere
    assign format_ok = (chr[2] == CHAR_DASH) && (chr[5] == CHAR_DASH)
                     && is_digit[0] && is_digit[1] && is_digit[3] && is_digit[4]
                     && is_digit[6] && is_digit[7] && is_digit[8] && is_digit[9];

    // field values
    assign day_raw   = two_digit(dig[0], dig[1]);
    assign month_raw = two_digit(dig[3], dig[4]);
    assign century   = two_digit(dig[6], dig[7]);
    assign yy        = two_digit(dig[8], dig[9]);

    // leap year from the century and year-of-century parts
    assign leap = ((yy != 7'd0) && (yy[1:0] == 2'd0))
               || ((yy == 7'd0) && (century[1:0] == 2'd0));

    // range checks
    assign month_ok = (month_raw >= 7'd1) && (month_raw <= 7'd12);
    assign dim      = month_len(month_raw[3:0], leap);
    assign day_ok   = (day_raw >= 7'd1) && (day_raw <= 7'(dim));

    // fields for the day count, with the year divisions already rounded up
    always_comb
    begin
        date_next.ok      = format_ok && month_ok && day_ok;
        date_next.year    = YEAR_W'(YEAR_W'(century) * YEAR_W'(100)) + YEAR_W'(yy);
        date_next.month   = month_raw[3:0];
        date_next.day     = day_raw[4:0];
        date_next.leap    = leap;
        date_next.ceil100 = century + 7'(yy != 7'd0);
        date_next.ceil400 = 5'(century[6:2])
                          + 5'((yy != 7'd0) || (century[1:0] != 2'd0));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            date_reg <= date_next;
        end
    end

    assign date = date_reg;

endmodule

// ----- src/dvd_day_count.sv -----
// day count stage: turns a decoded date into its day number
`timescale 1ns / 1ps

module dvd_day_count (
    input  logic                          clk,
    input  logic                          en,
    input  dvd_pkg::dvd_date_t            date,
    output logic                          ok,
    output logic [dvd_pkg::DAY_NUM_W-1:0] day_num
);
    import dvd_pkg::*;

    logic [YEAR_W:0]    year_p3;
    logic [DAY_NUM_W-1:0] year_days;
    logic [DAY_NUM_W-1:0] total;
    logic [DAY_NUM_W-1:0] day_num_next;
    logic [DAY_NUM_W-1:0] day_num_reg;
    logic                 ok_reg;

    // whole years before this one, leap days counted in closed form
    assign year_p3   = {1'b0, date.year} + (YEAR_W+1)'(3);
    assign year_days = DAY_NUM_W'(date.year) * DAY_NUM_W'(DAYS_PER_YEAR);

    // add months before this one and the day itself
    assign total = year_days
                 + DAY_NUM_W'(year_p3[YEAR_W:2])
                 + DAY_NUM_W'(date.ceil400)
                 - DAY_NUM_W'(date.ceil100)
                 + DAY_NUM_W'(days_before(date.month))
                 + DAY_NUM_W'(date.leap && (date.month > 4'd2))
                 + DAY_NUM_W'(date.day);

    assign day_num_next = date.ok ? total : '0;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            day_num_reg <= day_num_next;
            ok_reg      <= date.ok;
        end
    end

    assign ok      = ok_reg;
    assign day_num = day_num_reg;

endmodule

// ----- src/date_validate_and_day_difference.sv -----
// top level: validates two dd-mm-yyyy dates and gives day numbers and distance
// a result is shown once its transaction has moved through all four register stages
// throughput: one transaction per cycle unless result.ready stalls, four register stages with per-stage flow control
// stages: input register, character decode, day count, distance and result register
// reset: asynchronous active low, clears every stage valid; payload registers are not reset
`timescale 1ns / 1ps
`include "date_validate_and_day_difference_defines.svh"

module date_validate_and_day_difference (
    input  logic clk,
    input  logic rst_n,
    dvd_in_if.sink    dates,
    dvd_out_if.source result
);
    import dvd_pkg::*;

    logic a_valid_reg, a_valid_next;
    logic b_valid_reg, b_valid_next;
    logic c_valid_reg, c_valid_next;
    logic d_valid_reg, d_valid_next;
    logic a_ready, b_ready, c_ready, d_ready;

    logic [63:0] a_first_high_reg;
    logic [15:0] a_first_low_reg;
    logic [63:0] a_second_high_reg;
    logic [15:0] a_second_low_reg;

    dvd_date_t first_date;
    dvd_date_t second_date;

    logic                 first_ok, second_ok;
    logic [DAY_NUM_W-1:0] first_num, second_num;

    logic                 d_first_ok_reg, d_second_ok_reg;
    logic [DAY_NUM_W-1:0] d_first_num_reg, d_second_num_reg;
    logic [DAY_NUM_W-1:0] d_apart_reg, d_apart_next;

    // a stage loads when it is empty or its contents move on
    assign d_ready     = !d_valid_reg || result.ready;
    assign c_ready     = !c_valid_reg || d_ready;
    assign b_ready     = !b_valid_reg || c_ready;
    assign a_ready     = !a_valid_reg || b_ready;
    assign dates.ready = a_ready;

    always_comb
    begin
        a_valid_next = a_ready ? dates.valid : a_valid_reg;
        b_valid_next = b_ready ? a_valid_reg : b_valid_reg;
        c_valid_next = c_ready ? b_valid_reg : c_valid_reg;
        d_valid_next = d_ready ? c_valid_reg : d_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            c_valid_reg <= c_valid_next;
            d_valid_reg <= d_valid_next;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (a_ready)
        begin
            a_first_high_reg  <= dates.first_text_high;
            a_first_low_reg   <= dates.first_text_low;
            a_second_high_reg <= dates.second_text_high;
            a_second_low_reg  <= dates.second_text_low;
        end
    end

    // character decode, one per date
    dvd_decode u_decode_first (
        .clk       (clk),
        .en        (b_ready),
        .text_high (a_first_high_reg),
        .text_low  (a_first_low_reg),
        .date      (first_date)
    );

    dvd_decode u_decode_second (
        .clk       (clk),
        .en        (b_ready),
        .text_high (a_second_high_reg),
        .text_low  (a_second_low_reg),
        .date      (second_date)
    );

    // day count, one per date
    dvd_day_count u_count_first (
        .clk     (clk),
        .en      (c_ready),
        .date    (first_date),
        .ok      (first_ok),
        .day_num (first_num)
    );

    dvd_day_count u_count_second (
        .clk     (clk),
        .en      (c_ready),
        .date    (second_date),
        .ok      (second_ok),
        .day_num (second_num)
    );

    // distance between the two day numbers
    always_comb
    begin
        if (!(first_ok && second_ok))
        begin
            d_apart_next = '0;
        end
        else if (first_num >= second_num)
        begin
            d_apart_next = first_num - second_num;
        end
        else
        begin
            d_apart_next = second_num - first_num;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (d_ready)
        begin
            d_first_ok_reg   <= first_ok;
            d_second_ok_reg  <= second_ok;
            d_first_num_reg  <= first_num;
            d_second_num_reg <= second_num;
            d_apart_reg      <= d_apart_next;
        end
    end

    assign result.valid             = d_valid_reg;
    assign result.first_valid       = d_first_ok_reg;
    assign result.second_valid      = d_second_ok_reg;
    assign result.first_day_number  = d_first_num_reg;
    assign result.second_day_number = d_second_num_reg;
    assign result.days_apart        = d_apart_reg;

    // checks
    `DVD_ASSERT_NEXT(a_take_fills_input, dates.valid && dates.ready, a_valid_reg)
    `DVD_ASSERT(a_first_zero, (result.valid && !result.first_valid) |-> (result.first_day_number == '0))
    `DVD_ASSERT(a_second_zero, (result.valid && !result.second_valid) |-> (result.second_day_number == '0))
    `DVD_ASSERT(a_apart_zero, (result.valid && !(result.first_valid && result.second_valid)) |-> (result.days_apart == '0))
    `DVD_ASSERT(a_apart_bound, (result.valid && result.first_valid && result.second_valid) |-> ((result.days_apart <= result.first_day_number) || (result.days_apart <= result.second_day_number)))

endmodule
